/* rtl/core/lpfs_pkg.sv */
// Package for the length-prefixed frame splitter.
// Holds the frame layout constants, the parse phase type and the result struct.
// No dependencies.
package lpfs_pkg;

    // frame layout
    localparam int LENGTH_BYTES  = 4;
    localparam int ADDRESS_BYTES = 4;
    localparam int HEADER_BYTES  = 2 * ADDRESS_BYTES;

    // counter and field widths
    localparam int CNT_W  = 32;
    localparam int ADDR_W = 32;
    localparam int BYTE_W = 8;

    // parse phases
    typedef enum logic [1:0] {
        PH_LENGTH  = 2'd0,
        PH_HEADER  = 2'd1,
        PH_PAYLOAD = 2'd2,
        PH_SKIP    = 2'd3
    } t_phase;

    // one result item
    typedef struct packed {
        logic [ADDR_W-1:0] target_addr;
        logic [ADDR_W-1:0] sub_addr;
        logic [BYTE_W-1:0] payload_byte;
        logic              has_data;
        logic              message_end;
        logic              short_error;
    } t_result;

    // place one byte into a little-endian word at byte position pos
    function automatic logic [ADDR_W-1:0] le_insert(
        input logic [ADDR_W-1:0] acc,
        input logic [1:0]        pos,
        input logic [BYTE_W-1:0] b
    );
        logic [ADDR_W-1:0] ext;
        ext = {{(ADDR_W-BYTE_W){1'b0}}, b};
        return acc | (ext << {pos, 3'b000});
    endfunction

endpackage

/* rtl/core/lpfs_parse.sv */
// Frame parser: phase state machine, byte counter and captured header fields.
// Consumes one byte per enable and produces at most one result item.
// Depends on lpfs_pkg.
module lpfs_parse import lpfs_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic [BYTE_W-1:0] i_byte,
    output logic              o_res_valid,
    output t_result           o_res
);

    t_phase            r_phase, n_phase;
    logic [CNT_W-1:0]  r_cnt, n_cnt;
    logic [CNT_W-1:0]  r_decl, n_decl;
    logic [ADDR_W-1:0] r_first, n_first;
    logic [ADDR_W-1:0] r_second, n_second;
    logic [CNT_W-1:0]  cnt_inc;
    logic [CNT_W-1:0]  decl_base;
    logic [CNT_W-1:0]  sub_pos;

    assign cnt_inc = CNT_W'(r_cnt + 1'b1);
    assign sub_pos = CNT_W'(r_cnt - CNT_W'(ADDRESS_BYTES));

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_LENGTH;
            r_cnt    <= '0;
            r_decl   <= '0;
            r_first  <= '0;
            r_second <= '0;
        end else if (i_en) begin
            r_phase  <= n_phase;
            r_cnt    <= n_cnt;
            r_decl   <= n_decl;
            r_first  <= n_first;
            r_second <= n_second;
        end
    end

    // next state and result
    // the payload phase keeps counting from the header size, so its end
    // test compares against the declared length directly
    always_comb begin
        n_phase     = r_phase;
        n_cnt       = cnt_inc;
        n_decl      = r_decl;
        n_first     = r_first;
        n_second    = r_second;
        o_res_valid = 1'b0;
        o_res       = '0;
        decl_base   = (r_cnt == '0) ? '0 : r_decl;
        unique case (r_phase)
            PH_LENGTH: begin
                n_decl = le_insert(decl_base, r_cnt[1:0], i_byte);
                if (cnt_inc >= CNT_W'(LENGTH_BYTES)) begin
                    n_cnt = '0;
                    if (n_decl < CNT_W'(HEADER_BYTES)) begin
                        n_phase           = (n_decl == '0) ? PH_LENGTH : PH_SKIP;
                        o_res_valid       = 1'b1;
                        o_res.message_end = 1'b1;
                        o_res.short_error = 1'b1;
                    end else begin
                        n_first  = '0;
                        n_second = '0;
                        n_phase  = PH_HEADER;
                    end
                end
            end
            PH_HEADER: begin
                if (r_cnt < CNT_W'(ADDRESS_BYTES))
                    n_first = le_insert(r_first, r_cnt[1:0], i_byte);
                else
                    n_second = le_insert(r_second, sub_pos[1:0], i_byte);
                if (cnt_inc >= CNT_W'(HEADER_BYTES)) begin
                    if (r_decl == CNT_W'(HEADER_BYTES)) begin
                        n_cnt             = '0;
                        n_phase           = PH_LENGTH;
                        o_res_valid       = 1'b1;
                        o_res.target_addr = n_first;
                        o_res.sub_addr    = n_second;
                        o_res.message_end = 1'b1;
                    end else begin
                        n_phase = PH_PAYLOAD;
                    end
                end
            end
            PH_PAYLOAD: begin
                o_res_valid        = 1'b1;
                o_res.target_addr  = r_first;
                o_res.sub_addr     = r_second;
                o_res.payload_byte = i_byte;
                o_res.has_data     = 1'b1;
                if (cnt_inc >= r_decl) begin
                    o_res.message_end = 1'b1;
                    n_cnt             = '0;
                    n_phase           = PH_LENGTH;
                end
            end
            PH_SKIP: begin
                if (cnt_inc >= r_decl) begin
                    n_cnt   = '0;
                    n_phase = PH_LENGTH;
                end
            end
            default: begin
                n_phase = PH_LENGTH;
                n_cnt   = '0;
            end
        endcase
    end

endmodule

/* rtl/core/lpfs_out_reg.sv */
// Output register for result items with valid/ready handshake.
// Holds one finished result until the receiver takes it.
// Depends on lpfs_pkg.
module lpfs_out_reg import lpfs_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_load,
    input  t_result i_res,
    input  logic    i_ready,
    output logic    o_valid,
    output t_result o_res
);

    logic    r_valid;
    t_result r_res;

    // valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res <= i_res;
        end
    end

    assign o_valid = r_valid;
    assign o_res   = r_res;

endmodule

/* rtl/core/length_prefixed_frame_splitter.sv */
// Top level of the length-prefixed frame splitter.
// Instantiates the parser and the output register; depends on lpfs_pkg.
//
// Usage:
//   Input channel (i_in_valid / o_in_ready) carries one stream byte per item.
//   Each message is a 4-byte little-endian length (header plus payload), two
//   4-byte little-endian addresses, then the payload. Output channel
//   (o_out_valid / i_out_ready) gives one item per payload byte tagged with
//   both addresses, message_end on the last one. An empty payload gives one
//   marker item; a length below the header size gives one short_error item
//   and the declared number of following bytes are dropped.
//   An item that produces a result passes from the input register through
//   the parser into the output register.
//   Throughput: one byte per cycle unless the receiver stalls, set by the
//   combinational parse step between the input and output registers.
//   Reset (synchronous, active low) returns the parser to the length phase
//   and empties both registers.
//   When the receiver stalls with a result held, the input register still
//   drains bytes that give no result; o_in_ready drops once a waiting byte
//   needs the occupied output slot.
module length_prefixed_frame_splitter import lpfs_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic [BYTE_W-1:0] i_stream_byte,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic [ADDR_W-1:0] o_target_addr,
    output logic [ADDR_W-1:0] o_sub_addr,
    output logic [BYTE_W-1:0] o_payload_byte,
    output logic              o_has_data,
    output logic              o_message_end,
    output logic              o_short_error
);

    logic              r_in_valid;
    logic [BYTE_W-1:0] r_in_byte;
    logic              res_valid;
    t_result           res;
    t_result           out_res;
    logic              advance;

    // the held byte moves on when it gives no result or the output slot frees
    assign advance    = r_in_valid && (!res_valid || !o_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || advance;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in_byte <= i_stream_byte;
        end
    end

    // parser
    lpfs_parse u_parse (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_en        (advance),
        .i_byte      (r_in_byte),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    // result register
    lpfs_out_reg u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (advance && res_valid),
        .i_res   (res),
        .i_ready (i_out_ready),
        .o_valid (o_out_valid),
        .o_res   (out_res)
    );

    assign o_target_addr  = out_res.target_addr;
    assign o_sub_addr     = out_res.sub_addr;
    assign o_payload_byte = out_res.payload_byte;
    assign o_has_data     = out_res.has_data;
    assign o_message_end  = out_res.message_end;
    assign o_short_error  = out_res.short_error;

endmodule
